/* rtl/crspl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crspl_pkg
// Shared types and fixed constants of the Catmull-Rom spline evaluator.
// ----------------------------------------------------------------------------
package crspl_pkg;

  localparam int PORT_W       = 32;
  localparam int T_W          = 17;
  localparam int FRAC_W       = 16;
  localparam int MUL_W        = 33;
  localparam int BASIS_W      = 53;
  localparam int BASIS_SHIFT  = 25;
  localparam int WEIGHT_SHIFT = 24;

  localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_EVAL  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_EVAL  = 2'd0,
    ST_DONE  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage

/* rtl/crspl_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crspl_store
// Control point memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module crspl_store #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 96
) (
  input  logic                    clk_i,
  input  crspl_pkg::store_ctl_t   ctl_i,
  input  logic [ADDR_W-1:0]       wr_addr_i,
  input  logic [DATA_W-1:0]       wr_data_i,
  input  logic [ADDR_W-1:0]       rd_addr_i,
  output logic [DATA_W-1:0]       rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

/* rtl/catmull_rom_spline_evaluator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_spline_evaluator_core
// Uniform Catmull-Rom evaluator over a memory of 3D Q16.16 control points.
// ----------------------------------------------------------------------------
// One word is taken at a time. An add, a clear, an unused command or an
// evaluate on an empty store goes straight from acceptance to the result
// state; an evaluate passes first through TN, U, U2, U3, W, the MX/MY/MZ loop,
// ACC and FIN. Its length is set by the single shared 33x33 multiplier, which
// forms t*N, u^2 and u^3 and then the twelve weight-by-coordinate products, one
// per cycle, fed by the one read port of the point memory. A finished result
// sits in the output register until it is taken; a new word is accepted only
// after the previous result has moved there, so a stalled output also stalls input.
module catmull_rom_spline_evaluator_core #(
  parameter int MAX_POINTS  = 256,
  parameter int COORD_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            command_i,
  input  logic signed [crspl_pkg::PORT_W-1:0]   point_x_i,
  input  logic signed [crspl_pkg::PORT_W-1:0]   point_y_i,
  input  logic signed [crspl_pkg::PORT_W-1:0]   point_z_i,
  input  logic [crspl_pkg::T_W-1:0]             param_t_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [crspl_pkg::PORT_W-1:0]   out_x_o,
  output logic signed [crspl_pkg::PORT_W-1:0]   out_y_o,
  output logic signed [crspl_pkg::PORT_W-1:0]   out_z_o,
  output logic [1:0]                            status_o
);

  localparam int PORT_W  = crspl_pkg::PORT_W;
  localparam int CW      = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int NW      = $clog2(MAX_POINTS + 1);
  localparam int AW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int BW      = crspl_pkg::BASIS_W;
  localparam int WW      = BW - crspl_pkg::BASIS_SHIFT;
  localparam int ACC_W   = WW + CW + 2;
  localparam int RW      = ACC_W - crspl_pkg::WEIGHT_SHIFT;
  localparam int MW      = crspl_pkg::MUL_W;
  localparam int PW      = 2 * MW;
  localparam int FW      = crspl_pkg::FRAC_W;

  localparam logic [NW-1:0]          MAX_N     = NW'(MAX_POINTS);
  localparam logic signed [BW-1:0]   TWO_Q48   = BW'(64'd2 << 48);
  localparam logic signed [BW-1:0]   HALF_B    = BW'(64'd1 << (crspl_pkg::BASIS_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] HALF_ACC =
    ACC_W'(64'd1 << (crspl_pkg::WEIGHT_SHIFT - 1));
  localparam logic signed [RW-1:0]   SAT_HI    = RW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [RW-1:0]   SAT_LO    = ~SAT_HI;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TN   = 4'd1;
  localparam logic [3:0] S_U    = 4'd2;
  localparam logic [3:0] S_U2   = 4'd3;
  localparam logic [3:0] S_U3   = 4'd4;
  localparam logic [3:0] S_W    = 4'd5;
  localparam logic [3:0] S_MX   = 4'd6;
  localparam logic [3:0] S_MY   = 4'd7;
  localparam logic [3:0] S_MZ   = 4'd8;
  localparam logic [3:0] S_ACC  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]               state_q, state_d;
  logic [NW-1:0]            count_q, count_d;
  logic [1:0]               k_q, k_d;
  logic                     out_valid_q, out_valid_d;

  logic [crspl_pkg::T_W-1:0] t_q;
  logic [NW-1:0]            p_q;
  logic [FW-1:0]            u_q;
  logic [2*FW-1:0]          u2_q;
  logic [3*FW-1:0]          u3_q;
  logic signed [WW-1:0]     w_q [4];
  logic signed [PW-1:0]     prod_q;
  logic signed [ACC_W-1:0]  acc_x_q, acc_y_q, acc_z_q;
  logic signed [CW-1:0]     res_x_q, res_y_q, res_z_q;
  logic [1:0]               res_status_q;
  logic signed [CW-1:0]     out_x_q, out_y_q, out_z_q;
  logic [1:0]               out_status_q;

  crspl_pkg::store_ctl_t    store_ctl;
  logic [1:0]               rd_k;
  logic signed [NW+1:0]     cand;
  logic [NW-1:0]            last_idx;
  logic [NW-1:0]            idx_full;
  logic [3*CW-1:0]          rd_data;
  logic signed [CW-1:0]     rd_x, rd_y, rd_z;

  logic signed [MW-1:0]     mul_a, mul_b;
  logic signed [PW-1:0]     prod_d;
  logic signed [ACC_W-1:0]  prod_ext;

  logic signed [BW-1:0]     u1s, u2s, u3s;
  logic signed [BW-1:0]     basis [4];
  logic signed [BW-1:0]     basis_rnd [4];
  logic signed [WW-1:0]     w_d [4];

  logic                     take_in;
  logic                     load_out;
  logic [1:0]               in_status;

  function automatic logic signed [CW-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    logic signed [RW-1:0]    r;
    s = a + HALF_ACC;
    r = s[ACC_W-1:crspl_pkg::WEIGHT_SHIFT];
    if (r > SAT_HI) begin
      round_sat = SAT_HI[CW-1:0];
    end else if (r < SAT_LO) begin
      round_sat = SAT_LO[CW-1:0];
    end else begin
      round_sat = r[CW-1:0];
    end
  endfunction

  assign take_in  = (state_q == S_IDLE) && in_valid_i;
  assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // status of an accepted word before any evaluation
  always_comb begin
    in_status = crspl_pkg::ST_DONE;
    priority if ((command_i == crspl_pkg::CMD_ADD) && (count_q >= MAX_N)) begin
      in_status = crspl_pkg::ST_FULL;
    end else if ((command_i == crspl_pkg::CMD_EVAL) && (count_q == '0)) begin
      in_status = crspl_pkg::ST_EMPTY;
    end else begin
      in_status = crspl_pkg::ST_DONE;
    end
  end

  // segment index clamp
  always_comb begin
    cand     = $signed({2'b00, p_q}) + $signed((NW + 2)'(rd_k)) - $signed((NW + 2)'(1));
    last_idx = count_q - NW'(1);
    if (cand < $signed((NW + 2)'(0))) begin
      idx_full = '0;
    end else if (cand >= $signed({2'b00, last_idx})) begin
      idx_full = last_idx;
    end else begin
      idx_full = cand[NW-1:0];
    end
  end

  crspl_store #(
    .DEPTH  (MAX_POINTS),
    .ADDR_W (AW),
    .DATA_W (3 * CW)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (store_ctl),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i ({point_x_i[CW-1:0], point_y_i[CW-1:0], point_z_i[CW-1:0]}),
    .rd_addr_i (idx_full[AW-1:0]),
    .rd_data_o (rd_data)
  );

  assign rd_x = rd_data[3*CW-1:2*CW];
  assign rd_y = rd_data[2*CW-1:CW];
  assign rd_z = rd_data[CW-1:0];

  // basis weights, doubled in q.48 then rounded to q.24
  always_comb begin
    u1s = $signed({{(BW - 3 * FW){1'b0}}, u_q, {(2 * FW){1'b0}}});
    u2s = $signed({{(BW - 3 * FW){1'b0}}, u2_q, {FW{1'b0}}});
    u3s = $signed({{(BW - 3 * FW){1'b0}}, u3_q});
    basis[0] = (u2s <<< 1) - u3s - u1s;
    basis[1] = (u3s <<< 1) + u3s - (u2s <<< 2) - u2s + TWO_Q48;
    basis[2] = (u2s <<< 2) + u1s - (u3s <<< 1) - u3s;
    basis[3] = u3s - u2s;
    for (int k = 0; k < 4; k++) begin
      basis_rnd[k] = basis[k] + HALF_B;
      w_d[k]       = basis_rnd[k][BW-1:crspl_pkg::BASIS_SHIFT];
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_TN: begin
        mul_a = MW'(t_q);
        mul_b = MW'(count_q);
      end
      S_U: begin
        mul_a = MW'(prod_q[FW-1:0]);
        mul_b = MW'(prod_q[FW-1:0]);
      end
      S_U2: begin
        mul_a = MW'(prod_q[2*FW-1:0]);
        mul_b = MW'(u_q);
      end
      S_MX: begin
        mul_a = MW'(w_q[k_q]);
        mul_b = MW'(rd_x);
      end
      S_MY: begin
        mul_a = MW'(w_q[k_q]);
        mul_b = MW'(rd_y);
      end
      S_MZ: begin
        mul_a = MW'(w_q[k_q]);
        mul_b = MW'(rd_z);
      end
      default: begin
      end
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign prod_ext = ACC_W'($signed(prod_q[WW+CW-1:0]));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    store_ctl   = '0;
    rd_k        = 2'd0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DONE;
          unique case (command_i)
            crspl_pkg::CMD_ADD: begin
              if (count_q < MAX_N) begin
                store_ctl.wr_en = 1'b1;
                count_d         = count_q + NW'(1);
              end
            end
            crspl_pkg::CMD_CLEAR: count_d = '0;
            crspl_pkg::CMD_EVAL: begin
              if (count_q != '0) begin
                state_d = S_TN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_TN:  state_d = S_U;
      S_U:   state_d = S_U2;
      S_U2:  state_d = S_U3;
      S_U3:  state_d = S_W;
      S_W: begin
        store_ctl.rd_en = 1'b1;
        rd_k            = 2'd0;
        k_d             = 2'd0;
        state_d         = S_MX;
      end
      S_MX:  state_d = S_MY;
      S_MY:  state_d = S_MZ;
      S_MZ: begin
        if (k_q == 2'd3) begin
          state_d = S_ACC;
        end else begin
          store_ctl.rd_en = 1'b1;
          rd_k            = k_q + 2'd1;
          k_d             = k_q + 2'd1;
          state_d         = S_MX;
        end
      end
      S_ACC: state_d = S_FIN;
      S_FIN: state_d = S_DONE;
      S_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      k_q         <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (take_in) begin
      res_x_q      <= '0;
      res_y_q      <= '0;
      res_z_q      <= '0;
      res_status_q <= in_status;
      t_q          <= (param_t_i > crspl_pkg::ONE_Q16) ? crspl_pkg::ONE_Q16 : param_t_i;
    end
    unique case (state_q)
      S_U: begin
        p_q <= prod_q[FW +: NW];
        u_q <= prod_q[FW-1:0];
      end
      S_U2: u2_q <= prod_q[2*FW-1:0];
      S_U3: u3_q <= prod_q[3*FW-1:0];
      S_W: begin
        for (int k = 0; k < 4; k++) begin
          w_q[k] <= w_d[k];
        end
        acc_x_q <= '0;
        acc_y_q <= '0;
        acc_z_q <= '0;
      end
      S_MX: begin
        if (k_q != 2'd0) begin
          acc_z_q <= acc_z_q + prod_ext;
        end
      end
      S_MY:  acc_x_q <= acc_x_q + prod_ext;
      S_MZ:  acc_y_q <= acc_y_q + prod_ext;
      S_ACC: acc_z_q <= acc_z_q + prod_ext;
      S_FIN: begin
        res_x_q      <= round_sat(acc_x_q);
        res_y_q      <= round_sat(acc_y_q);
        res_z_q      <= round_sat(acc_z_q);
        res_status_q <= crspl_pkg::ST_EVAL;
      end
      S_DONE: begin
        if (load_out) begin
          out_x_q      <= res_x_q;
          out_y_q      <= res_y_q;
          out_z_q      <= res_z_q;
          out_status_q <= res_status_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_x_o     = PORT_W'(out_x_q);
  assign out_y_o     = PORT_W'(out_y_q);
  assign out_z_o     = PORT_W'(out_z_q);
  assign status_o    = out_status_q;

endmodule

/* rtl/crspl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crspl_checker
// Port-level checks of the spline evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module crspl_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic [1:0]                          command_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [crspl_pkg::PORT_W-1:0] out_x_o,
  input logic signed [crspl_pkg::PORT_W-1:0] out_y_o,
  input logic signed [crspl_pkg::PORT_W-1:0] out_z_o,
  input logic [1:0]                          status_o
);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_x_o) &&
      $stable(out_y_o) && $stable(out_z_o) && $stable(status_o))
    else $error("stalled result word changed");

  // only an evaluated word carries coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != crspl_pkg::ST_EVAL) |->
      (out_x_o == '0) && (out_y_o == '0) && (out_z_o == '0))
    else $error("non-evaluate word has non-zero coordinates");

  // one word in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again straight after acceptance");

  // an evaluate never completes in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i == crspl_pkg::CMD_EVAL) |=>
      !in_ready_o && !$rose(out_valid_o))
    else $error("evaluate word finished too early");

endmodule

bind catmull_rom_spline_evaluator_core crspl_checker u_crspl_checker (.*);

/* tb/catmull_rom_spline_evaluator_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_spline_evaluator_core_tb
// Self-checking bench for the Catmull-Rom spline evaluator core.
// ----------------------------------------------------------------------------
// Words are fed through the input handshake from a queue that is filled at
// start-up. The queue holds a short directed run (empty store, extreme
// coordinates, overshoot into saturation, t at and above one, unused command)
// and then random build-and-evaluate sequences, store fills past capacity and
// noise. Every accepted word is run through a bit-exact fixed-point model of
// the point store and the basis blend. Every result taken from the output
// handshake is checked field by field against the oldest prediction. Both
// sides stall in random bursts.
// ----------------------------------------------------------------------------
module catmull_rom_spline_evaluator_core_tb;

  localparam int PORT_W = crspl_pkg::PORT_W;
  localparam int T_W = crspl_pkg::T_W;
  localparam int MAX_PTS = 256;
  localparam int N_RANDOM = 1800;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [PORT_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [PORT_W-1:0] C_MIN = 32'sh8000_0000;

  typedef struct {
    logic [1:0]              cmd;
    logic signed [PORT_W-1:0] px;
    logic signed [PORT_W-1:0] py;
    logic signed [PORT_W-1:0] pz;
    logic [T_W-1:0]          t;
    bit                      hold;
  } word_t;

  typedef struct {
    logic signed [PORT_W-1:0] x;
    logic signed [PORT_W-1:0] y;
    logic signed [PORT_W-1:0] z;
    crspl_pkg::status_e      status;
  } point_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = crspl_pkg::CMD_ADD;
  logic signed [PORT_W-1:0] point_x = '0;
  logic signed [PORT_W-1:0] point_y = '0;
  logic signed [PORT_W-1:0] point_z = '0;
  logic [T_W-1:0] param_t = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [PORT_W-1:0] out_x;
  logic signed [PORT_W-1:0] out_y;
  logic signed [PORT_W-1:0] out_z;
  logic [1:0] status;

  word_t      word_q[$];
  point_res_t due_results[$];
  word_t      cur;

  logic signed [PORT_W-1:0] pt_x [MAX_PTS];
  logic signed [PORT_W-1:0] pt_y [MAX_PTS];
  logic signed [PORT_W-1:0] pt_z [MAX_PTS];
  int pt_count = 0;

  int errors = 0;
  int n_add = 0, n_eval = 0, n_clear = 0, n_other = 0;
  int n_full = 0, n_empty = 0, n_sat = 0, n_checked = 0;
  int gap_left = 0, stall_left = 0;
  int unsigned cyc = 0;
  bit no_idle = 1'b0;

  always #4 clk_i = ~clk_i;

  catmull_rom_spline_evaluator_core #(
    .MAX_POINTS (MAX_PTS),
    .COORD_WIDTH(32)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .command_i  (command),
    .point_x_i  (point_x),
    .point_y_i  (point_y),
    .point_z_i  (point_z),
    .param_t_i  (param_t),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_x_o    (out_x),
    .out_y_o    (out_y),
    .out_z_o    (out_z),
    .status_o   (status)
  );

  // divide by 2^k, round to nearest, ties upward
  function automatic longint round_div(longint v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic logic signed [PORT_W-1:0] clip32(longint v);
    if (v > 64'sd2147483647) begin
      n_sat++;
      return C_MAX;
    end
    if (v < -64'sd2147483648) begin
      n_sat++;
      return C_MIN;
    end
    return v[PORT_W-1:0];
  endfunction

  function automatic int clamp_idx(longint i, int n);
    if (i < 0) return 0;
    if (i >= n - 1) return n - 1;
    return int'(i);
  endfunction

  function automatic logic signed [PORT_W-1:0] blend_axis(
    longint w0, longint w1, longint w2, longint w3,
    longint c0, longint c1, longint c2, longint c3);
    longint acc;
    acc = w0 * c0 + w1 * c1 + w2 * c2 + w3 * c3;
    return clip32(round_div(acc, crspl_pkg::WEIGHT_SHIFT));
  endfunction

  function automatic point_res_t spline_apply(word_t w);
    point_res_t r;
    longint tq, tn, u, u2, u3, uq, w0, w1, w2, w3;
    int p, i0, i1, i2, i3;
    r.x = '0;
    r.y = '0;
    r.z = '0;
    r.status = crspl_pkg::ST_DONE;
    case (w.cmd)
      crspl_pkg::CMD_ADD: begin
        n_add++;
        if (pt_count >= MAX_PTS) begin
          r.status = crspl_pkg::ST_FULL;
          n_full++;
        end else begin
          pt_x[pt_count] = w.px;
          pt_y[pt_count] = w.py;
          pt_z[pt_count] = w.pz;
          pt_count++;
        end
      end
      crspl_pkg::CMD_CLEAR: begin
        n_clear++;
        pt_count = 0;
      end
      crspl_pkg::CMD_EVAL: begin
        n_eval++;
        if (pt_count == 0) begin
          r.status = crspl_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          tq = (w.t > crspl_pkg::ONE_Q16) ? longint'(crspl_pkg::ONE_Q16) : longint'(w.t);
          tn = tq * pt_count;
          p  = int'(tn >> crspl_pkg::FRAC_W);
          u  = tn & 64'hFFFF;
          i0 = clamp_idx(p - 1, pt_count);
          i1 = clamp_idx(p, pt_count);
          i2 = clamp_idx(p + 1, pt_count);
          i3 = clamp_idx(p + 2, pt_count);
          u2 = u * u;
          u3 = u2 * u;
          u2 = u2 <<< 16;
          uq = u <<< 32;
          w0 = round_div(-u3 + 2 * u2 - uq, crspl_pkg::BASIS_SHIFT);
          w1 = round_div(3 * u3 - 5 * u2 + (64'sd2 <<< 48), crspl_pkg::BASIS_SHIFT);
          w2 = round_div(-3 * u3 + 4 * u2 + uq, crspl_pkg::BASIS_SHIFT);
          w3 = round_div(u3 - u2, crspl_pkg::BASIS_SHIFT);
          r.x = blend_axis(w0, w1, w2, w3, pt_x[i0], pt_x[i1], pt_x[i2], pt_x[i3]);
          r.y = blend_axis(w0, w1, w2, w3, pt_y[i0], pt_y[i1], pt_y[i2], pt_y[i3]);
          r.z = blend_axis(w0, w1, w2, w3, pt_z[i0], pt_z[i1], pt_z[i2], pt_z[i3]);
          r.status = crspl_pkg::ST_EVAL;
        end
      end
      default: n_other++;
    endcase
    return r;
  endfunction

  function automatic logic signed [PORT_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return C_MIN;
      1: return C_MAX;
      2, 3, 4: return $urandom_range(0, 32'h000F_FFFF) - 32'sh0008_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [T_W-1:0] rand_t();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return crspl_pkg::ONE_Q16;
      2: return T_W'($urandom_range(32'h10001, 32'h1FFFF));
      default: return T_W'($urandom_range(0, 32'h10000));
    endcase
  endfunction

  task automatic push_word(input logic [1:0] c, input logic signed [PORT_W-1:0] x,
                           input logic signed [PORT_W-1:0] y,
                           input logic signed [PORT_W-1:0] z,
                           input logic [T_W-1:0] t, input bit hold);
    word_t w;
    w.cmd = c;
    w.px = x;
    w.py = y;
    w.pz = z;
    w.t = t;
    w.hold = hold;
    word_q.insert(word_q.size(), w);
  endtask

  always @(posedge clk_i) cyc <= cyc + 1;

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.insert(due_results.size(), spline_apply(cur));
        if (!no_idle && ((cyc >> 9) % 3) != 0 && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 8);
        end
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (word_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (word_q[0].hold && due_results.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          cur = word_q.pop_front();
          command <= cur.cmd;
          point_x <= cur.px;
          point_y <= cur.py;
          point_z <= cur.pz;
          param_t <= cur.t;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    point_res_t exp_r;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result word with nothing expected: x %0d y %0d z %0d status %0d",
                 out_x, out_y, out_z, status);
          errors++;
        end else begin
          exp_r = due_results.pop_front();
          n_checked++;
          if (out_x !== exp_r.x) begin
            $error("out_x: expected %0d, got %0d", exp_r.x, out_x);
            errors++;
          end
          if (out_y !== exp_r.y) begin
            $error("out_y: expected %0d, got %0d", exp_r.y, out_y);
            errors++;
          end
          if (out_z !== exp_r.z) begin
            $error("out_z: expected %0d, got %0d", exp_r.z, out_z);
            errors++;
          end
          if (status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!no_idle && ((cyc >> 9) % 3) != 2 && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int made, npts, nev, k, fills;
    bit hold_next;
    made = 0;
    fills = 0;

    // directed
    push_word(crspl_pkg::CMD_EVAL, '0, '0, '0, 17'h08000, 1'b0);
    push_word(CMD_UNUSED, C_MAX, C_MIN, 32'sh1234_5678, 17'h1FFFF, 1'b0);
    push_word(crspl_pkg::CMD_ADD, C_MIN, C_MAX, '0, '0, 1'b0);
    push_word(crspl_pkg::CMD_EVAL, '0, '0, '0, '0, 1'b0);
    push_word(crspl_pkg::CMD_ADD, C_MAX, C_MIN, 32'sd1, '0, 1'b0);
    push_word(crspl_pkg::CMD_ADD, C_MAX, C_MIN, -32'sd1, '0, 1'b0);
    push_word(crspl_pkg::CMD_ADD, C_MIN, C_MAX, 32'sh7FFF_0000, '0, 1'b0);
    push_word(crspl_pkg::CMD_EVAL, '0, '0, '0, 17'h06000, 1'b0);
    push_word(crspl_pkg::CMD_EVAL, '0, '0, '0, crspl_pkg::ONE_Q16, 1'b0);
    push_word(crspl_pkg::CMD_EVAL, '0, '0, '0, 17'h1FFFF, 1'b0);
    push_word(crspl_pkg::CMD_EVAL, '0, '0, '0, 17'h00001, 1'b0);
    push_word(crspl_pkg::CMD_EVAL, '0, '0, '0, 17'h0FFFF, 1'b0);
    push_word(crspl_pkg::CMD_EVAL, '0, '0, '0, 17'h0AAAA, 1'b0);
    push_word(crspl_pkg::CMD_CLEAR, C_MAX, C_MAX, C_MAX, 17'h1FFFF, 1'b0);
    push_word(crspl_pkg::CMD_EVAL, '0, '0, '0, crspl_pkg::ONE_Q16, 1'b0);
    push_word(crspl_pkg::CMD_ADD, 32'sh0001_0000, 32'shFFFF_0000, 32'sh5555_5555, '0, 1'b0);
    push_word(crspl_pkg::CMD_ADD, 32'sh0002_0000, 32'shAAAA_AAAA, 32'sh0000_8000, '0, 1'b0);
    push_word(crspl_pkg::CMD_EVAL, '0, '0, '0, 17'h05555, 1'b0);
    push_word(CMD_UNUSED, 32'sh0F0F_0F0F, 32'sh7070_7070, C_MIN, 17'h15555, 1'b0);
    push_word(crspl_pkg::CMD_EVAL, '0, '0, '0, 17'h15555, 1'b0);
    push_word(crspl_pkg::CMD_ADD, '0, '0, '0, '0, 1'b0);
    push_word(crspl_pkg::CMD_EVAL, '0, '0, '0, 17'h08000, 1'b0);
    push_word(crspl_pkg::CMD_CLEAR, '0, '0, '0, '0, 1'b0);

    // random sequences
    hold_next = 1'b1;
    while (made < N_RANDOM) begin
      if ($urandom_range(0, 99) < 85) begin
        push_word(crspl_pkg::CMD_CLEAR, rand_coord(), rand_coord(), rand_coord(),
                  rand_t(), hold_next);
        hold_next = 1'b0;
        made++;
        if ((fills == 0 && made > 900) || (fills < 2 && $urandom_range(0, 29) == 0)) begin
          npts = $urandom_range(MAX_PTS, MAX_PTS + 6);
          fills++;
        end else if ($urandom_range(0, 9) == 0) begin
          npts = $urandom_range(13, 64);
        end else begin
          npts = $urandom_range(1, 12);
        end
        for (k = 0; k < npts; k++) begin
          push_word(crspl_pkg::CMD_ADD, rand_coord(), rand_coord(), rand_coord(),
                    rand_t(), 1'b0);
        end
        nev = $urandom_range(3, 12);
        for (k = 0; k < nev; k++) begin
          push_word(crspl_pkg::CMD_EVAL, rand_coord(), rand_coord(), rand_coord(),
                    rand_t(), 1'b0);
        end
        made += npts + nev;
      end else begin
        nev = $urandom_range(1, 5);
        for (k = 0; k < nev; k++) begin
          push_word(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(),
                    T_W'($urandom_range(0, 32'h1FFFF)), hold_next);
          hold_next = 1'b0;
        end
        made += nev;
      end
      if ((made % 300) < 12) hold_next = 1'b1;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (word_q.size() != 0 || in_valid) begin
      if (word_q.size() < 150) no_idle = 1'b1;
      @(posedge clk_i);
    end
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("covered %0d adds (%0d dropped on a full store), %0d clears, %0d other commands",
             n_add, n_full, n_clear, n_other);
    $display("covered %0d evaluations (%0d on an empty store), %0d clipped axes, %0d checked",
             n_eval, n_empty, n_sat, n_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("timeout: input or output handshake stuck");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
rtl/crspl_pkg.sv
rtl/crspl_store.sv
rtl/catmull_rom_spline_evaluator_core.sv
rtl/crspl_checker.sv
tb/catmull_rom_spline_evaluator_core_tb.sv
